// File: rtl/dpbp_pkg.sv
// shared types and constants for the depth pixel back projection block
// no dependencies; imported by every module of the block

package dpbp_pkg;

   // default largest frame side, sets the raster counter width
   localparam int unsigned MAX_SIDE_DEFAULT = 4096;

   // depth of the queue between the pixel front end and the projection back end
   localparam int unsigned QUEUE_DEPTH_DEFAULT = 4;

   // fixed field widths
   localparam int unsigned DEPTH_W  = 16;
   localparam int unsigned COLOUR_W = 24;
   localparam int unsigned SIDE_W   = 13;
   localparam int unsigned OFFS_W   = 14;
   localparam int unsigned SCALE_W  = 32;
   localparam int unsigned POS_W    = 32;
   localparam int unsigned POSZ_W   = 31;
   localparam int unsigned CSR_IDX_W  = 3;
   localparam int unsigned CSR_DATA_W = 32;
   localparam int unsigned REQ_DATA_W = 40;
   localparam int unsigned RSP_DATA_W = 120;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_COLS_PER_ROW    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ROWS_PER_FRAME  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_COL_OFFSET      = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_ROW_OFFSET      = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_INV_FOCAL_SCALE = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_INV_DEPTH_SCALE = 3'd5;

   // register reset values
   localparam logic [SIDE_W-1:0]  RST_COLS_PER_ROW    = 13'd640;
   localparam logic [SIDE_W-1:0]  RST_ROWS_PER_FRAME  = 13'd480;
   localparam logic [OFFS_W-1:0]  RST_COL_OFFSET      = 14'h3EC0;  // -320
   localparam logic [OFFS_W-1:0]  RST_ROW_OFFSET      = 14'h3F10;  // -240
   localparam logic [SCALE_W-1:0] RST_INV_FOCAL_SCALE = 32'd8590;
   localparam logic [SCALE_W-1:0] RST_INV_DEPTH_SCALE = 32'd4294967;

   // half lsb of q16.16 when rounding a q.32 product
   localparam logic [15:0] ROUND_HALF = 16'h8000;

   // per-pixel items that do not depend on the counter width
   typedef struct packed {
      logic [DEPTH_W-1:0]  depth_mm;
      logic [COLOUR_W-1:0] colour;
      logic                frame_end;
      logic                neg_x;
      logic                neg_y;
   } dpbp_pixel_type;

endpackage

// File: rtl/dpbp_front.sv
// pixel front end: raster counters, line and frame end, signed pixel offsets
// depends on dpbp_pkg

module dpbp_front import dpbp_pkg::*; #(
   parameter int unsigned MAX_SIDE = MAX_SIDE_DEFAULT,
   parameter int unsigned CNT_W    = $clog2(MAX_SIDE),
   parameter int unsigned MAG_W    = ((CNT_W + 1 > OFFS_W) ? CNT_W + 1 : OFFS_W)
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 pix_valid,
   output logic                 pix_ready,
   input  logic [DEPTH_W-1:0]   pix_depth,
   input  logic [COLOUR_W-1:0]  pix_colour,
   input  logic [SIDE_W-1:0]    cols_per_row,
   input  logic [SIDE_W-1:0]    rows_per_frame,
   input  logic [OFFS_W-1:0]    col_offset,
   input  logic [OFFS_W-1:0]    row_offset,
   output logic                 push_valid,
   input  logic                 push_ready,
   output logic [MAG_W-1:0]     push_mag_x,
   output logic [MAG_W-1:0]     push_mag_y,
   output dpbp_pixel_type       push_pixel
);

   localparam int unsigned G_W = MAG_W + 1;

   logic [CNT_W-1:0] col_ff, col_in;
   logic [CNT_W-1:0] row_ff, row_in;
   logic [31:0]      width_clamp, height_clamp;
   logic [CNT_W-1:0] last_col, last_row;
   logic             line_end, frame_end, accept;
   logic [G_W-1:0]   g_x, g_y, ng_x, ng_y;

   always_comb begin
      if (cols_per_row == '0) begin
         width_clamp = 32'd1;
      end else if ({19'd0, cols_per_row} > 32'(MAX_SIDE)) begin
         width_clamp = 32'(MAX_SIDE);
      end else begin
         width_clamp = {19'd0, cols_per_row};
      end
      if (rows_per_frame == '0) begin
         height_clamp = 32'd1;
      end else if ({19'd0, rows_per_frame} > 32'(MAX_SIDE)) begin
         height_clamp = 32'(MAX_SIDE);
      end else begin
         height_clamp = {19'd0, rows_per_frame};
      end
   end

   assign last_col  = CNT_W'(width_clamp - 32'd1);
   assign last_row  = CNT_W'(height_clamp - 32'd1);
   assign line_end  = col_ff >= last_col;
   assign frame_end = line_end && (row_ff >= last_row);

   // signed position relative to the optical centre
   assign g_x  = {{(G_W-CNT_W){1'b0}}, col_ff} + {{(G_W-OFFS_W){col_offset[OFFS_W-1]}}, col_offset};
   assign g_y  = {{(G_W-CNT_W){1'b0}}, row_ff} + {{(G_W-OFFS_W){row_offset[OFFS_W-1]}}, row_offset};
   assign ng_x = '0 - g_x;
   assign ng_y = '0 - g_y;

   assign push_valid = pix_valid;
   assign pix_ready  = push_ready;
   assign accept     = pix_valid && push_ready;

   assign push_mag_x           = g_x[G_W-1] ? ng_x[MAG_W-1:0] : g_x[MAG_W-1:0];
   assign push_mag_y           = g_y[G_W-1] ? ng_y[MAG_W-1:0] : g_y[MAG_W-1:0];
   assign push_pixel.depth_mm  = pix_depth;
   assign push_pixel.colour    = pix_colour;
   assign push_pixel.frame_end = frame_end;
   assign push_pixel.neg_x     = g_x[G_W-1];
   assign push_pixel.neg_y     = g_y[G_W-1];

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (accept) begin
         if (line_end) begin
            col_in = '0;
            row_in = frame_end ? '0 : row_ff + CNT_W'(1);
         end else begin
            col_in = col_ff + CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   a_line_wrap: assert property (@(posedge clock) disable iff (reset)
      (accept && line_end && !frame_end) |=> (col_ff == '0 && row_ff == $past(row_ff) + CNT_W'(1)))
      else $error("line end did not advance the row");

   a_frame_wrap: assert property (@(posedge clock) disable iff (reset)
      (accept && frame_end) |=> (col_ff == '0 && row_ff == '0))
      else $error("frame end did not clear the counters");

endmodule

// File: rtl/dpbp_queue.sv
// short first-in first-out queue between the front end and the back end
// depends on dpbp_pkg for the default depth

module dpbp_queue import dpbp_pkg::*; #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = QUEUE_DEPTH_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  logic [WIDTH-1:0] in_data,
   output logic             out_valid,
   input  logic             out_ready,
   output logic [WIDTH-1:0] out_data
);

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] data_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             push, pop;

   assign in_ready  = count_ff < CNT_W'(DEPTH);
   assign out_valid = count_ff != '0;
   assign out_data  = data_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      case ({push, pop})
         2'b10:   count_in = count_ff + CNT_W'(1);
         2'b01:   count_in = count_ff - CNT_W'(1);
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         data_ff[wr_ptr_ff] <= in_data;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("queue fill beyond depth");

   a_push_only: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> (count_ff == $past(count_ff) + CNT_W'(1)))
      else $error("queue fill did not follow a push");

endmodule

// File: rtl/dpbp_back.sv
// projection back end: three-stage multiply, round and saturate pipeline
// depends on dpbp_pkg

module dpbp_back import dpbp_pkg::*; #(
   parameter int unsigned MAG_W = OFFS_W
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 item_valid,
   output logic                 item_ready,
   input  logic [MAG_W-1:0]     item_mag_x,
   input  logic [MAG_W-1:0]     item_mag_y,
   input  dpbp_pixel_type       item_pixel,
   input  logic [SCALE_W-1:0]   inv_focal_scale,
   input  logic [SCALE_W-1:0]   inv_depth_scale,
   output logic                 out_valid,
   input  logic                 out_ready,
   output logic [POS_W-1:0]     out_pos_x,
   output logic [POS_W-1:0]     out_pos_y,
   output logic [POSZ_W-1:0]    out_pos_z,
   output logic [COLOUR_W-1:0]  out_colour,
   output logic                 out_frame_end
);

   localparam int unsigned P1_W = MAG_W + DEPTH_W;
   localparam int unsigned P2_W = P1_W + SCALE_W;
   localparam int unsigned PZ_W = DEPTH_W + SCALE_W;
   localparam int unsigned RX_W = P2_W + 1 - 16;
   localparam int unsigned RZ_W = PZ_W + 1 - 16;

   logic advance;

   // stage 1: offset times depth, depth times depth scale
   logic                s1_valid_ff;
   logic [P1_W-1:0]     s1_px_ff, s1_py_ff;
   logic [PZ_W-1:0]     s1_pz_ff;
   dpbp_pixel_type      s1_pix_ff;
   // stage 2: times focal scale
   logic                s2_valid_ff;
   logic [P2_W-1:0]     s2_px_ff, s2_py_ff, s2_px_in, s2_py_in;
   logic [PZ_W-1:0]     s2_pz_ff;
   dpbp_pixel_type      s2_pix_ff;
   // stage 3: rounded and saturated result register
   logic                s3_valid_ff;
   logic [POS_W-1:0]    s3_x_ff, s3_y_ff, s3_x_in, s3_y_in;
   logic [POSZ_W-1:0]   s3_z_ff, s3_z_in;
   logic [COLOUR_W-1:0] s3_colour_ff;
   logic                s3_last_ff;

   logic [P2_W:0]       sum_x, sum_y;
   logic [RX_W-1:0]     rx, ry;
   logic [PZ_W:0]       sum_z;
   logic [RZ_W-1:0]     rz;

   // the whole pipeline moves together unless the result register is held
   assign advance    = !s3_valid_ff || out_ready;
   assign item_ready = advance;

   assign s2_px_in = P2_W'(s1_px_ff) * P2_W'(inv_focal_scale);
   assign s2_py_in = P2_W'(s1_py_ff) * P2_W'(inv_focal_scale);

   assign sum_x = (P2_W+1)'(s2_px_ff) + (P2_W+1)'(ROUND_HALF);
   assign sum_y = (P2_W+1)'(s2_py_ff) + (P2_W+1)'(ROUND_HALF);
   assign sum_z = (PZ_W+1)'(s2_pz_ff) + (PZ_W+1)'(ROUND_HALF);
   assign rx    = sum_x[P2_W:16];
   assign ry    = sum_y[P2_W:16];
   assign rz    = sum_z[PZ_W:16];

   always_comb begin
      if (!s2_pix_ff.neg_x) begin
         s3_x_in = (rx > RX_W'(32'h7FFF_FFFF)) ? 32'h7FFF_FFFF : rx[POS_W-1:0];
      end else begin
         s3_x_in = (rx > RX_W'(33'h1_0000_0000 >> 1)) ? 32'h8000_0000
                                                     : 32'd0 - rx[POS_W-1:0];
      end
      if (!s2_pix_ff.neg_y) begin
         s3_y_in = (ry > RX_W'(32'h7FFF_FFFF)) ? 32'h7FFF_FFFF : ry[POS_W-1:0];
      end else begin
         s3_y_in = (ry > RX_W'(33'h1_0000_0000 >> 1)) ? 32'h8000_0000
                                                     : 32'd0 - ry[POS_W-1:0];
      end
      s3_z_in = (rz > RZ_W'(32'h7FFF_FFFF)) ? 31'h7FFF_FFFF : rz[POSZ_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= item_valid;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_px_ff     <= P1_W'(item_mag_x) * P1_W'(item_pixel.depth_mm);
         s1_py_ff     <= P1_W'(item_mag_y) * P1_W'(item_pixel.depth_mm);
         s1_pz_ff     <= PZ_W'(item_pixel.depth_mm) * PZ_W'(inv_depth_scale);
         s1_pix_ff    <= item_pixel;
         s2_px_ff     <= s2_px_in;
         s2_py_ff     <= s2_py_in;
         s2_pz_ff     <= s1_pz_ff;
         s2_pix_ff    <= s1_pix_ff;
         s3_x_ff      <= s3_x_in;
         s3_y_ff      <= s3_y_in;
         s3_z_ff      <= s3_z_in;
         s3_colour_ff <= s2_pix_ff.colour;
         s3_last_ff   <= s2_pix_ff.frame_end;
      end
   end

   assign out_valid     = s3_valid_ff;
   assign out_pos_x     = s3_x_ff;
   assign out_pos_y     = s3_y_ff;
   assign out_pos_z     = s3_z_ff;
   assign out_colour    = s3_colour_ff;
   assign out_frame_end = s3_last_ff;

   a_stall_freeze: assert property (@(posedge clock) disable iff (reset)
      (s3_valid_ff && !out_ready) |=> ($stable(s1_valid_ff) && $stable(s2_valid_ff)))
      else $error("pipeline moved while the result was held");

endmodule

// File: rtl/depth_pixel_back_projection_top.sv
// top level of the depth pixel back projection block: ports, registers, wiring
// depends on dpbp_pkg, dpbp_front, dpbp_queue and dpbp_back

// Turns a raster-ordered depth stream into a point cloud. Each request carries
// one pixel (16-bit depth in millimetres and a BGR colour); internal column and
// row counters place it in the frame, and the response gives x, y and z in
// metres as Q16.16 (x and y signed and saturated, z saturated to 31 bits), the
// colour unchanged and tlast on the frame's last pixel. A zero depth gives the
// point at the origin. While rsp_tready is high the block sustains one pixel
// per clock: the front end classifies a pixel in the cycle it is accepted and
// writes it to a four-entry queue, and the back end takes one pixel per cycle
// from the queue through a three-stage multiply, round and saturate pipeline
// that ends in the stage 3 result register. When rsp_tready is low the back
// end holds still and the queue fills before req_tready drops. The user must
// write frame size and offsets through the csr port only while no pixel is in
// flight; the block does not enforce this. A width or height of zero acts as
// one, values above MAX_SIDE act as MAX_SIDE, and a size change mid-frame ends
// the line or frame at the new last index.

module depth_pixel_back_projection_top import dpbp_pkg::*; #(
   parameter int unsigned MAX_SIDE    = MAX_SIDE_DEFAULT,
   parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   // pixel requests
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,   // depth_mm, colour_bgr
   // point responses
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,   // pos_x, pos_y, pos_z, point_colour, zero pad
   output logic                  rsp_tlast,   // frame_end
   // register writes
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wr_data
);

   // counter width and the widest offset magnitude that reaches the multipliers
   localparam int unsigned CNT_W   = $clog2(MAX_SIDE);
   localparam int unsigned MAG_W   = (CNT_W + 1 > OFFS_W) ? CNT_W + 1 : OFFS_W;
   localparam int unsigned PIX_W   = $bits(dpbp_pixel_type);
   localparam int unsigned ENTRY_W = 2 * MAG_W + PIX_W;

   // configuration registers
   logic [SIDE_W-1:0]  cols_per_row_ff;
   logic [SIDE_W-1:0]  rows_per_frame_ff;
   logic [OFFS_W-1:0]  col_offset_ff;
   logic [OFFS_W-1:0]  row_offset_ff;
   logic [SCALE_W-1:0] inv_focal_scale_ff;
   logic [SCALE_W-1:0] inv_depth_scale_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cols_per_row_ff    <= RST_COLS_PER_ROW;
         rows_per_frame_ff  <= RST_ROWS_PER_FRAME;
         col_offset_ff      <= RST_COL_OFFSET;
         row_offset_ff      <= RST_ROW_OFFSET;
         inv_focal_scale_ff <= RST_INV_FOCAL_SCALE;
         inv_depth_scale_ff <= RST_INV_DEPTH_SCALE;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_COLS_PER_ROW:    cols_per_row_ff    <= csr_wr_data[SIDE_W-1:0];
            CSR_ROWS_PER_FRAME:  rows_per_frame_ff  <= csr_wr_data[SIDE_W-1:0];
            CSR_COL_OFFSET:      col_offset_ff      <= csr_wr_data[OFFS_W-1:0];
            CSR_ROW_OFFSET:      row_offset_ff      <= csr_wr_data[OFFS_W-1:0];
            CSR_INV_FOCAL_SCALE: inv_focal_scale_ff <= csr_wr_data;
            CSR_INV_DEPTH_SCALE: inv_depth_scale_ff <= csr_wr_data;
            default:             ;  // unknown index, write dropped
         endcase
      end
   end

   // front end to queue
   logic              push_valid, push_ready;
   logic [MAG_W-1:0]  push_mag_x, push_mag_y;
   dpbp_pixel_type    push_pixel;

   // queue to back end
   logic              pop_valid, pop_ready;
   logic [ENTRY_W-1:0] pop_entry;
   logic [MAG_W-1:0]  pop_mag_x, pop_mag_y;
   dpbp_pixel_type    pop_pixel;

   logic [POS_W-1:0]    pos_x, pos_y;
   logic [POSZ_W-1:0]   pos_z;
   logic [COLOUR_W-1:0] point_colour;

   dpbp_front #(
      .MAX_SIDE (MAX_SIDE),
      .CNT_W    (CNT_W),
      .MAG_W    (MAG_W)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .pix_valid      (req_tvalid),
      .pix_ready      (req_tready),
      .pix_depth      (req_tdata[DEPTH_W-1:0]),
      .pix_colour     (req_tdata[DEPTH_W +: COLOUR_W]),
      .cols_per_row   (cols_per_row_ff),
      .rows_per_frame (rows_per_frame_ff),
      .col_offset     (col_offset_ff),
      .row_offset     (row_offset_ff),
      .push_valid     (push_valid),
      .push_ready     (push_ready),
      .push_mag_x     (push_mag_x),
      .push_mag_y     (push_mag_y),
      .push_pixel     (push_pixel)
   );

   dpbp_queue #(
      .WIDTH (ENTRY_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (push_valid),
      .in_ready  (push_ready),
      .in_data   ({push_mag_x, push_mag_y, push_pixel}),
      .out_valid (pop_valid),
      .out_ready (pop_ready),
      .out_data  (pop_entry)
   );

   assign pop_mag_x = pop_entry[ENTRY_W-1 -: MAG_W];
   assign pop_mag_y = pop_entry[PIX_W +: MAG_W];
   assign pop_pixel = dpbp_pixel_type'(pop_entry[PIX_W-1:0]);

   dpbp_back #(
      .MAG_W (MAG_W)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .item_valid      (pop_valid),
      .item_ready      (pop_ready),
      .item_mag_x      (pop_mag_x),
      .item_mag_y      (pop_mag_y),
      .item_pixel      (pop_pixel),
      .inv_focal_scale (inv_focal_scale_ff),
      .inv_depth_scale (inv_depth_scale_ff),
      .out_valid       (rsp_tvalid),
      .out_ready       (rsp_tready),
      .out_pos_x       (pos_x),
      .out_pos_y       (pos_y),
      .out_pos_z       (pos_z),
      .out_colour      (point_colour),
      .out_frame_end   (rsp_tlast)
   );

   // response packing, lowest field first, one pad bit to a whole byte
   assign rsp_tdata = {1'b0, point_colour, pos_z, pos_y, pos_x};

endmodule
